FILE: rtl/nvt_pkg.sv
`default_nettype none
package nvt_pkg;

    localparam int TOP_COUNT = 10;
    localparam int CNT_W     = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

    localparam int VOTE_W  = 16;
    localparam int COORD_W = 10;
    localparam int SCALE_W = 2;
    localparam int ROT_W   = 6;
    localparam int FUNC_W  = 2;
    localparam int DATA_W  = 64;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_OFFER = 2'd0,
        FUNC_DUMP  = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DUMP = 1'b1
    } state_t;

    typedef struct packed {
        logic [ROT_W-1:0]   rot_b;
        logic [ROT_W-1:0]   rot_a;
        logic [SCALE_W-1:0] scale;
        logic [COORD_W-1:0] frame;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
        logic [VOTE_W-1:0]  vote;
    } cand_t;

    typedef struct packed {
        logic  valid;
        cand_t data;
    } entry_t;

    typedef struct packed {
        logic offer;
        logic clear;
        logic rotate;
    } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/nvt_cell.sv
`default_nettype none
module nvt_cell (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  nvt_pkg::cell_ctrl_t ctrl,
    input  nvt_pkg::entry_t     cand,
    input  nvt_pkg::entry_t     prev,
    input  wire                 prev_ge,
    input  nvt_pkg::entry_t     next,
    output nvt_pkg::entry_t     entry,
    output logic                ge
);

    logic          valid_reg, valid_next;
    nvt_pkg::cand_t data_reg, data_next;

    // candidate ranks at or ahead of this slot
    assign ge = !valid_reg || (data_reg.vote <= cand.data.vote);

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctrl.clear) begin
            valid_next = 1'b0;
        end else if (ctrl.rotate) begin
            valid_next = next.valid;
            data_next  = next.data;
        end else if (ctrl.offer && ge) begin
            if (prev_ge) begin
                // shift down from the slot above
                valid_next = prev.valid;
                data_next  = prev.data;
            end else begin
                valid_next = cand.valid;
                data_next  = cand.data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign entry.valid = valid_reg;
    assign entry.data  = data_reg;

endmodule
`default_nettype wire

FILE: rtl/nvt_ctrl.sv
`default_nettype none
module nvt_ctrl (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire [nvt_pkg::FUNC_W-1:0]   s_func,
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic                        m_tlast,
    output nvt_pkg::cell_ctrl_t         ctrl
);

    nvt_pkg::state_t           state_reg, state_next;
    logic [nvt_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      s_acc, m_acc, at_last;

    assign at_last = (cnt_reg == nvt_pkg::CNT_W'(nvt_pkg::TOP_COUNT - 1));

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        m_tlast     = 1'b0;
        ctrl.offer  = 1'b0;
        ctrl.clear  = 1'b0;
        ctrl.rotate = 1'b0;
        s_acc       = 1'b0;
        m_acc       = 1'b0;
        case (state_reg)
            nvt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                s_acc    = s_tvalid;
                if (s_acc) begin
                    case (nvt_pkg::func_t'(s_func))
                        nvt_pkg::FUNC_OFFER: ctrl.offer = 1'b1;
                        nvt_pkg::FUNC_CLEAR: ctrl.clear = 1'b1;
                        nvt_pkg::FUNC_DUMP: begin
                            state_next = nvt_pkg::ST_DUMP;
                            cnt_next   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            nvt_pkg::ST_DUMP: begin
                m_tvalid = 1'b1;
                m_tlast  = at_last;
                m_acc    = m_tready;
                if (m_acc) begin
                    // row rotates by one slot per result, back home after a full pass
                    ctrl.rotate = 1'b1;
                    if (at_last) begin
                        state_next = nvt_pkg::ST_IDLE;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default: state_next = nvt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nvt_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/top_n_vote_tracker.sv
`default_nettype none
// Keeps the TOP_COUNT highest-voted candidates in descending vote order, a newer candidate
// going ahead of older ones with an equal vote. The request kind travels in s_tuser: offer
// and clear give no result, so offers stream in at one per cycle while no dump is in flight;
// a dump gives TOP_COUNT results in rank order, one per cycle that m_tready is high, and no
// request is taken until its last result is out. Both figures come from the row of slot
// cells: an offer is a single compare-and-shift step across the row, and a dump rotates the
// row by one slot per result so that slot 0 always feeds the output. Empty slots read out
// with m_tuser low and zero data; m_tlast marks the final slot.
module top_n_vote_tracker (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    // vote[15:0], pos_x[25:16], pos_y[35:26], frame_idx[45:36], scale_idx[47:46],
    // rot_a_idx[53:48], rot_b_idx[59:54], zero fill
    input  wire [nvt_pkg::DATA_W-1:0]   s_tdata,
    // func[1:0]
    input  wire [nvt_pkg::FUNC_W-1:0]   s_tuser,
    output logic                        m_tvalid,
    input  wire                         m_tready,
    // out_vote[15:0], out_x[25:16], out_y[35:26], out_frame[45:36], out_scale[47:46],
    // out_rot_a[53:48], out_rot_b[59:54], zero fill
    output logic [nvt_pkg::DATA_W-1:0]  m_tdata,
    // slot_valid[0]
    output logic [0:0]                  m_tuser,
    output logic                        m_tlast
);

    localparam int N = nvt_pkg::TOP_COUNT;

    nvt_pkg::cell_ctrl_t ctrl;
    nvt_pkg::entry_t     cand;
    nvt_pkg::entry_t     row [N];
    logic                ge  [N];

    assign cand.valid = 1'b1;
    assign cand.data  = nvt_pkg::cand_t'(s_tdata[$bits(nvt_pkg::cand_t)-1:0]);

    nvt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_func   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .ctrl     (ctrl)
    );

    for (genvar i = 0; i < N; i++) begin : g_cell
        nvt_pkg::entry_t prev_e;
        logic            prev_g;
        if (i == 0) begin : g_head
            assign prev_e = cand;
            assign prev_g = 1'b0;
        end else begin : g_body
            assign prev_e = row[i-1];
            assign prev_g = ge[i-1];
        end
        nvt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .cand    (cand),
            .prev    (prev_e),
            .prev_ge (prev_g),
            .next    (row[(i + 1) % N]),
            .entry   (row[i]),
            .ge      (ge[i])
        );
    end

    assign m_tuser[0] = row[0].valid;
    assign m_tdata    = row[0].valid
                      ? nvt_pkg::DATA_W'(row[0].data)
                      : '0;

endmodule
`default_nettype wire

FILE: rtl/nvt_checker.sv
`default_nettype none
module nvt_checker (
    input wire                        aclk,
    input wire                        aresetn,
    input wire                        s_tvalid,
    input wire                        s_tready,
    input wire [nvt_pkg::FUNC_W-1:0]  s_tuser,
    input wire                        m_tvalid,
    input wire                        m_tready,
    input wire [nvt_pkg::DATA_W-1:0]  m_tdata,
    input wire [0:0]                  m_tuser,
    input wire                        m_tlast
);

    // no request taken while a dump is in flight
    a_dump_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("request accepted during dump");

    a_dump_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == nvt_pkg::FUNC_DUMP) |=> m_tvalid)
        else $error("dump request gave no result");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
        else $error("dump did not end after last slot");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("empty slot with nonzero data");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind top_n_vote_tracker nvt_checker u_nvt_checker (.*);
`default_nettype wire

FILE: tb/top_n_vote_tracker_tb.sv
`default_nettype none
module top_n_vote_tracker_tb;

    // code 3 has no meaning in the block and must be ignored
    localparam logic [nvt_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [nvt_pkg::FUNC_W-1:0] func;
        nvt_pkg::cand_t             cand;
    } request_t;

    typedef struct packed {
        logic           valid;
        nvt_pkg::cand_t data;
        logic           last;
    } ranked_slot_t;

    logic                         aclk;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    wire                          s_tready;
    logic [nvt_pkg::DATA_W-1:0]   s_tdata  = '0;
    logic [nvt_pkg::FUNC_W-1:0]   s_tuser  = '0;
    wire                          m_tvalid;
    logic                         m_tready = 1'b0;
    wire  [nvt_pkg::DATA_W-1:0]   m_tdata;
    wire  [0:0]                   m_tuser;
    wire                          m_tlast;

    top_n_vote_tracker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    request_t     pending_requests[$];
    ranked_slot_t expected_slots[$];

    // shadow copy of the ranked list
    nvt_pkg::cand_t rank_entry[nvt_pkg::TOP_COUNT];
    logic           rank_occupied[nvt_pkg::TOP_COUNT];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (got_v !== exp_v)
            report_mismatch($sformatf("%s expected %0h got %0h", name, exp_v, got_v));
    endtask

    function automatic void clear_ranking();
        for (int k = 0; k < nvt_pkg::TOP_COUNT; k++) begin
            rank_entry[k]    = '0;
            rank_occupied[k] = 1'b0;
        end
    endfunction

    function automatic void rank_request(input request_t r);
        int           pos;
        ranked_slot_t s;
        case (r.func)
            nvt_pkg::FUNC_OFFER: begin
                pos = 0;
                // equal votes: the newcomer goes ahead
                while (pos < nvt_pkg::TOP_COUNT && rank_occupied[pos] &&
                       rank_entry[pos].vote > r.cand.vote)
                    pos++;
                if (pos < nvt_pkg::TOP_COUNT) begin
                    for (int j = nvt_pkg::TOP_COUNT - 1; j > pos; j--) begin
                        rank_entry[j]    = rank_entry[j-1];
                        rank_occupied[j] = rank_occupied[j-1];
                    end
                    rank_entry[pos]    = r.cand;
                    rank_occupied[pos] = 1'b1;
                end
            end
            nvt_pkg::FUNC_DUMP: begin
                for (int k = 0; k < nvt_pkg::TOP_COUNT; k++) begin
                    s.valid = rank_occupied[k];
                    s.data  = rank_occupied[k] ? rank_entry[k] : '0;
                    s.last  = (k == nvt_pkg::TOP_COUNT - 1);
                    expected_slots.push_back(s);
                end
            end
            nvt_pkg::FUNC_CLEAR: clear_ranking();
            default: ;
        endcase
    endfunction

    initial clear_ranking();

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid)
                rank_request(request_t'({s_tuser, s_tdata[$bits(nvt_pkg::cand_t)-1:0]}));
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                request_t r;
                r = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= r.func;
                s_tdata  <= {{(nvt_pkg::DATA_W - $bits(nvt_pkg::cand_t)){1'b0}}, r.cand};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result monitor
    always @(posedge aclk) begin : result_monitor
        ranked_slot_t   exp_s;
        nvt_pkg::cand_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(nvt_pkg::cand_t)-1:0];
            if (expected_slots.size() == 0) begin
                report_mismatch($sformatf("unexpected result data %0h", m_tdata));
            end else begin
                exp_s = expected_slots.pop_front();
                check_field("slot_valid", 16'(exp_s.valid),      16'(m_tuser[0]));
                check_field("out_vote",   16'(exp_s.data.vote),  16'(got.vote));
                check_field("out_x",      16'(exp_s.data.x),     16'(got.x));
                check_field("out_y",      16'(exp_s.data.y),     16'(got.y));
                check_field("out_frame",  16'(exp_s.data.frame), 16'(got.frame));
                check_field("out_scale",  16'(exp_s.data.scale), 16'(got.scale));
                check_field("out_rot_a",  16'(exp_s.data.rot_a), 16'(got.rot_a));
                check_field("out_rot_b",  16'(exp_s.data.rot_b), 16'(got.rot_b));
                check_field("last",       16'(exp_s.last),       16'(m_tlast));
            end
        end
    end

    function automatic request_t make_request(input logic [nvt_pkg::FUNC_W-1:0] func,
                                              input logic [nvt_pkg::VOTE_W-1:0] vote);
        request_t r;
        r.func       = func;
        r.cand.vote  = vote;
        r.cand.x     = nvt_pkg::COORD_W'($urandom);
        r.cand.y     = nvt_pkg::COORD_W'($urandom);
        r.cand.frame = nvt_pkg::COORD_W'($urandom);
        r.cand.scale = nvt_pkg::SCALE_W'($urandom);
        r.cand.rot_a = nvt_pkg::ROT_W'($urandom);
        r.cand.rot_b = nvt_pkg::ROT_W'($urandom);
        return r;
    endfunction

    function automatic logic [nvt_pkg::VOTE_W-1:0] random_vote();
        int unsigned pick;
        pick = $urandom_range(99);
        // narrow range gives plenty of ties
        if (pick < 45)      return nvt_pkg::VOTE_W'($urandom_range(15));
        else if (pick < 52) return '0;
        else if (pick < 59) return '1;
        else                return nvt_pkg::VOTE_W'($urandom);
    endfunction

    // clear / offer burst / dump sequences with some noise mixed in
    task automatic queue_random_sequences(input int unsigned count);
        int unsigned queued;
        int unsigned offers;
        queued = 0;
        while (queued < count) begin
            if ($urandom_range(2) == 0) begin
                pending_requests.push_back(make_request(nvt_pkg::FUNC_CLEAR,
                                                        nvt_pkg::VOTE_W'($urandom)));
                queued++;
            end
            offers = $urandom_range(20, 2);
            repeat (offers) begin
                if ($urandom_range(19) == 0)
                    pending_requests.push_back(make_request(FUNC_UNUSED,
                                                            nvt_pkg::VOTE_W'($urandom)));
                else begin
                    pending_requests.push_back(make_request(nvt_pkg::FUNC_OFFER,
                                                            random_vote()));
                    queued++;
                end
            end
            if ($urandom_range(4) == 0) begin
                pending_requests.push_back(make_request(nvt_pkg::FUNC_DUMP,
                                                        nvt_pkg::VOTE_W'($urandom)));
                queued++;
            end
            pending_requests.push_back(make_request(nvt_pkg::FUNC_DUMP,
                                                    nvt_pkg::VOTE_W'($urandom)));
            queued++;
        end
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || s_tvalid || expected_slots.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        request_t r;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // empty list reads out all invalid
        pending_requests.push_back(make_request(nvt_pkg::FUNC_DUMP, '0));
        r = '0;
        r.func = nvt_pkg::FUNC_OFFER;
        pending_requests.push_back(r);
        r = '1;
        r.func = nvt_pkg::FUNC_OFFER;
        pending_requests.push_back(r);
        // tie with the all-ones candidate, ranks ahead of it
        pending_requests.push_back(make_request(nvt_pkg::FUNC_OFFER, '1));
        pending_requests.push_back(make_request(nvt_pkg::FUNC_DUMP, '0));
        // unused code leaves the list alone
        pending_requests.push_back(make_request(FUNC_UNUSED, 16'd500));
        pending_requests.push_back(make_request(nvt_pkg::FUNC_DUMP, '0));
        // overfill so entries get pushed off the end
        for (int i = 0; i < 11; i++)
            pending_requests.push_back(make_request(nvt_pkg::FUNC_OFFER, 16'(1000 + i * 7)));
        // lower than every held vote: dropped itself
        pending_requests.push_back(make_request(nvt_pkg::FUNC_OFFER, 16'd1));
        pending_requests.push_back(make_request(nvt_pkg::FUNC_DUMP, '0));
        pending_requests.push_back(make_request(nvt_pkg::FUNC_CLEAR, '1));
        pending_requests.push_back(make_request(nvt_pkg::FUNC_DUMP, '0));

        queue_random_sequences(30);
        wait_drained();

        send_idle_pct  = 69;
        recv_stall_pct = 0;
        queue_random_sequences(30);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 69;
        queue_random_sequences(30);
        wait_drained();

        send_idle_pct  = 33;
        recv_stall_pct = 33;
        queue_random_sequences(30);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (30) @(posedge aclk);
        if (expected_slots.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_slots.size()));
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
